>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/flac_lpc_pkg.sv
// ----------------------------------------------------------------------------
// FLAC LPC synthesis package
// Widths, codes and helper functions shared by the predictor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package flac_lpc_pkg;

    localparam int MAX_ORDER  = 32;
    localparam int SMP_W      = 32;
    localparam int COEF_W     = 15;
    localparam int PROD_W     = COEF_W + SMP_W;
    localparam int TAP_W      = $clog2(MAX_ORDER);
    localparam int CNT_W      = $clog2(MAX_ORDER + 1);
    localparam int ACC_W      = PROD_W + TAP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        KIND_COEF = 2'd0,
        KIND_WARM = 2'd1,
        KIND_RES  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 3'd0,
        CFG_ORDER  = 3'd1,
        CFG_QSHIFT = 3'd2,
        CFG_SWIDTH = 3'd3,
        CFG_CPREC  = 3'd4
    } t_cfg_idx;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic       issue;
        logic       clear;
        logic       fixed;
        logic [2:0] fix_order;
    } t_mac_ctl;

    // Sign-extends the low w bits of v; w of 32 or more keeps v as is.
    function automatic logic [SMP_W-1:0] sext_bits(input logic [SMP_W-1:0] v,
                                                   input logic [5:0] w);
        logic [SMP_W-1:0] m;
        logic [SMP_W-1:0] r;
        logic [4:0]       sb;
        m  = (32'd1 << w) - 32'd1;
        sb = 5'(w - 6'd1);
        if (w >= 6'd32) begin
            r = v;
        end else begin
            r = v & m;
            if (r[sb]) begin
                r = r | ~m;
            end
        end
        return r;
    endfunction

    // Reduces a coefficient slot into the range of the coefficient store.
    function automatic logic [TAP_W-1:0] slot_mod(input logic [4:0] s);
        logic [5:0] r;
        r = {1'b0, s};
        for (int i = 0; i < 8; i++) begin
            if (r >= 6'(MAX_ORDER)) begin
                r = r - 6'(MAX_ORDER);
            end
        end
        return TAP_W'(r);
    endfunction

    // Binomial predictor coefficients, newest sample at tap 0.
    function automatic logic signed [COEF_W-1:0] fixed_coef(input logic [2:0] ord,
                                                            input logic [TAP_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (ord)
            3'd1: begin
                if (tap == TAP_W'(0)) c = COEF_W'(1);
            end
            3'd2: begin
                if (tap == TAP_W'(0)) c = COEF_W'(2);
                if (tap == TAP_W'(1)) c = COEF_W'(-1);
            end
            3'd3: begin
                if (tap == TAP_W'(0)) c = COEF_W'(3);
                if (tap == TAP_W'(1)) c = COEF_W'(-3);
                if (tap == TAP_W'(2)) c = COEF_W'(1);
            end
            3'd4: begin
                if (tap == TAP_W'(0)) c = COEF_W'(4);
                if (tap == TAP_W'(1)) c = COEF_W'(-6);
                if (tap == TAP_W'(2)) c = COEF_W'(4);
                if (tap == TAP_W'(3)) c = COEF_W'(-1);
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/flac_lpc_if.sv
// ----------------------------------------------------------------------------
// FLAC LPC synthesis channel interfaces
// Input item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface flac_lpc_in_if import flac_lpc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [4:0]              slot;
    logic [SMP_W-1:0]        raw_bits;
    logic signed [SMP_W-1:0] residual;
    logic                    last;

    modport source (output valid, kind, slot, raw_bits, residual, last, input ready);
    modport sink   (input valid, kind, slot, raw_bits, residual, last, output ready);
endinterface

interface flac_lpc_out_if import flac_lpc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample;
    logic                    status;
    logic                    last_res;

    modport source (output valid, sample, status, last_res, input ready);
    modport sink   (input valid, sample, status, last_res, output ready);
endinterface

interface flac_lpc_cfg_if import flac_lpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/flac_lpc_hist.sv
// ----------------------------------------------------------------------------
// FLAC LPC sample history
// Shift line of past samples, newest at tap 0, with one selectable read tap.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_lpc_hist import flac_lpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [SMP_W-1:0] i_din,
    input  logic [TAP_W-1:0] i_raddr,
    output logic [SMP_W-1:0] o_rdata
);

    logic [SMP_W-1:0] r_hist [MAX_ORDER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_push) begin
            r_hist[0] <= i_din;
            for (int i = 1; i < MAX_ORDER; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    assign o_rdata = r_hist[i_raddr];

endmodule

`default_nettype wire

>>> hdl/flac_lpc_mac.sv
// ----------------------------------------------------------------------------
// FLAC LPC multiply-accumulate unit
// Coefficient store and a three-stage shared multiply-accumulate over taps.
// ----------------------------------------------------------------------------
`default_nettype none

module flac_lpc_mac import flac_lpc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctl                i_ctl,
    input  logic [TAP_W-1:0]        i_tap,
    input  logic [SMP_W-1:0]        i_hist,
    input  logic                    i_coef_we,
    input  logic [TAP_W-1:0]        i_coef_addr,
    input  logic [COEF_W-1:0]       i_coef_data,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_busy
);

    logic [COEF_W-1:0]        r_coef_mem [MAX_ORDER];
    logic signed [COEF_W-1:0] r_coef_rd;
    logic signed [COEF_W-1:0] r_fix_c;
    logic signed [SMP_W-1:0]  r_hist_s1;
    logic                     r_fixed1;
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [COEF_W-1:0] coef_sel;

    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef_mem[i_coef_addr] <= i_coef_data;
        end
        r_coef_rd <= r_coef_mem[i_tap];
    end

    // Stage one: operand fetch. Stage two: product. Stage three: accumulate.
    always_ff @(posedge i_clk) begin
        r_fix_c   <= fixed_coef(i_ctl.fix_order, i_tap);
        r_hist_s1 <= i_hist;
        r_fixed1  <= i_ctl.fixed;
        r_prod    <= coef_sel * r_hist_s1;
    end

    assign coef_sel = r_fixed1 ? r_fix_c : r_coef_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + {{TAP_W{r_prod[PROD_W-1]}}, r_prod};
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_v1 | r_v2;

endmodule

`default_nettype wire

>>> hdl/flac_lpc_synthesis_top.sv
// ----------------------------------------------------------------------------
// FLAC LPC synthesis top level
// Sequencer, configuration registers and result register of the predictor.
// ----------------------------------------------------------------------------
// Usage:
// i_in carries one word per item: coefficient load, warm-up sample or residual.
// o_out carries one word per warm-up sample or residual: the sample, a status
// flag and the copied last marker. i_cfg writes the five configuration
// registers and is always ready; write it only while the block is idle.
// A coefficient load gives no result. A warm-up sample goes from the idle
// state through the done state into the output register behind o_out.
// A residual with a predictor of n taps (n = order, at most 32 in custom mode,
// 0 to 4 in fixed mode) passes through the MAC, drain and done states for n of
// one or more: the shared multiply-accumulate unit walks one tap per cycle and
// drains three stages. Its result then goes into the output register.
// With no taps the unit is skipped: the drain state passes at once.
// An unsupported fixed order returns status 1 through the done state and
// leaves the history alone.
// i_in is ready only while the sequencer is idle. A stalled o_out holds its
// word; the next item is accepted meanwhile and waits for the register.
// Synchronous reset clears the history, the sequencer and the output valid,
// and loads the register reset values; no clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module flac_lpc_synthesis_top import flac_lpc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    flac_lpc_in_if.sink   i_in,
    flac_lpc_out_if.source o_out,
    flac_lpc_cfg_if.sink  i_cfg
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_tap, n_tap;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [SMP_W-1:0]  r_resid, n_resid;
    logic              r_last, n_last;
    logic [SMP_W-1:0]  r_sample, n_sample;
    logic              r_status, n_status;
    logic              r_push, n_push;
    logic              r_out_valid;
    logic [SMP_W-1:0]  r_out_sample;
    logic              r_out_status;
    logic              r_out_last;

    logic              r_mode;
    logic [5:0]        r_order;
    logic [3:0]        r_qshift;
    logic [5:0]        r_swidth;
    logic [3:0]        r_cprec;

    logic              in_acc;
    logic              out_free;
    logic              done_go;
    logic              mac_clear;
    logic [5:0]        warm_w;
    logic [SMP_W-1:0]  warm_smp;
    logic [SMP_W-1:0]  coef_ext;
    logic [COEF_W-1:0] coef_data;
    logic [CNT_W-1:0]  taps;
    logic [3:0]        shift;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [ACC_W-1:0] acc_sh;
    logic              mac_busy;
    logic [SMP_W-1:0]  hist_rd;
    t_mac_ctl          mac_ctl;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign done_go  = (r_state == ST_DONE) && out_free;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_order  <= '0;
            r_qshift <= '0;
            r_swidth <= 6'd16;
            r_cprec  <= 4'd15;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MODE:   r_mode   <= i_cfg.data[0];
                CFG_ORDER:  r_order  <= i_cfg.data[5:0];
                CFG_QSHIFT: r_qshift <= i_cfg.data[3:0];
                CFG_SWIDTH: r_swidth <= i_cfg.data[5:0];
                CFG_CPREC:  r_cprec  <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    assign warm_w    = (r_swidth == 6'd0) ? 6'd1 :
                       (r_swidth > 6'd32) ? 6'd32 : r_swidth;
    assign warm_smp  = sext_bits(i_in.raw_bits, warm_w);
    assign coef_ext  = sext_bits(i_in.raw_bits, {2'b00, r_cprec});
    assign coef_data = (r_cprec == 4'd0) ? '0 : coef_ext[COEF_W-1:0];

    assign taps  = r_mode ? ((r_order > 6'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(r_order))
                          : CNT_W'(r_order);
    assign shift = r_mode ? r_qshift : 4'd0;

    assign acc_sh = mac_acc >>> shift;

    always_comb begin
        n_state   = r_state;
        n_tap     = r_tap;
        n_n       = r_n;
        n_resid   = r_resid;
        n_last    = r_last;
        n_sample  = r_sample;
        n_status  = r_status;
        n_push    = r_push;
        mac_clear = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_last = i_in.last;
                    case (i_in.kind)
                        KIND_WARM: begin
                            n_sample = warm_smp;
                            n_status = 1'b0;
                            n_push   = 1'b1;
                            n_state  = ST_DONE;
                        end
                        KIND_RES: begin
                            if (!r_mode && (r_order > 6'd4)) begin
                                // Unsupported fixed order: report, keep history.
                                n_sample = '0;
                                n_status = 1'b1;
                                n_push   = 1'b0;
                                n_state  = ST_DONE;
                            end else begin
                                n_resid   = i_in.residual;
                                n_status  = 1'b0;
                                n_push    = 1'b1;
                                n_n       = taps;
                                n_tap     = '0;
                                mac_clear = 1'b1;
                                n_state   = (taps == '0) ? ST_DRAIN : ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                n_tap = r_tap + CNT_W'(1);
                if (r_tap == r_n - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    n_sample = r_resid + acc_sh[SMP_W-1:0];
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_n     <= n_n;
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_resid  <= n_resid;
        r_last   <= n_last;
        r_sample <= n_sample;
        r_status <= n_status;
        r_push   <= n_push;
        if (done_go) begin
            r_out_sample <= r_sample;
            r_out_status <= r_status;
            r_out_last   <= r_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.sample   = r_out_sample;
    assign o_out.status   = r_out_status;
    assign o_out.last_res = r_out_last;

    assign mac_ctl.issue     = (r_state == ST_MAC);
    assign mac_ctl.clear     = mac_clear;
    assign mac_ctl.fixed     = !r_mode;
    assign mac_ctl.fix_order = r_order[2:0];

    flac_lpc_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (done_go && r_push),
        .i_din   (r_sample),
        .i_raddr (r_tap[TAP_W-1:0]),
        .o_rdata (hist_rd)
    );

    flac_lpc_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_tap       (r_tap[TAP_W-1:0]),
        .i_hist      (hist_rd),
        .i_coef_we   (in_acc && (i_in.kind == KIND_COEF)),
        .i_coef_addr (slot_mod(i_in.slot)),
        .i_coef_data (coef_data),
        .o_acc       (mac_acc),
        .o_busy      (mac_busy)
    );

    `AST_SAME(a_ready_mac_idle, i_in.ready, !mac_busy, "input ready while the MAC is busy")
    `AST_SAME(a_tap_range, r_state == ST_MAC, r_tap < r_n, "tap counter beyond the order")
    `AST_NEXT(a_drain_wait, (r_state == ST_DRAIN) && mac_busy, r_state == ST_DRAIN,
              "left drain before the MAC pipeline emptied")
    `AST_NEXT(a_done_load, done_go, o_out.valid && (r_state == ST_IDLE),
              "finished word not loaded into the output register")

endmodule

`default_nettype wire

>>> tb/sv/flac_lpc_synthesis_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FLAC LPC synthesis checker
// Watches the item, result and register channels of the block, rebuilds each
// sample from its own copy of the history, coefficients and registers, and
// compares every result word field by field in order of arrival.
// ----------------------------------------------------------------------------
module flac_lpc_synthesis_checker import flac_lpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    flac_lpc_in_if  i_in,
    flac_lpc_out_if i_res,
    flac_lpc_cfg_if i_cfg,
    output int      o_fail_count,
    output int      o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             status;
        logic             last_res;
    } t_recon_word;

    logic [SMP_W-1:0]         history [MAX_ORDER];
    logic signed [COEF_W-1:0] coefs   [MAX_ORDER];
    logic                     mode_custom;
    logic [5:0]               pred_order;
    logic [3:0]               qshift;
    logic [5:0]               swidth;
    logic [3:0]               cprec;
    t_recon_word              expected_samples [$];

    function automatic logic [SMP_W-1:0] sign_extend_to(input logic [SMP_W-1:0] v,
                                                        input int w);
        logic signed [SMP_W-1:0] t;
        if (w >= SMP_W) begin
            return v;
        end
        t = v << (SMP_W - w);
        return t >>> (SMP_W - w);
    endfunction

    // Newest sample sits at index 0.
    function automatic void push_history(input logic [SMP_W-1:0] s);
        for (int i = MAX_ORDER - 1; i > 0; i--) begin
            history[i] = history[i-1];
        end
        history[0] = s;
    endfunction

    function automatic void reconstruct(input t_kind k, input logic [4:0] slot,
                                        input logic [SMP_W-1:0] raw,
                                        input logic [SMP_W-1:0] res, input logic lst);
        t_recon_word      w;
        longint           acc;
        int               taps;
        int               width;
        logic [SMP_W-1:0] pred;
        logic [SMP_W-1:0] h0, h1, h2, h3;
        w.sample   = '0;
        w.status   = 1'b0;
        w.last_res = lst;
        case (k)
            KIND_COEF: begin
                if (cprec == 4'd0) begin
                    coefs[slot % MAX_ORDER] = '0;
                end else begin
                    coefs[slot % MAX_ORDER] = COEF_W'(sign_extend_to(raw, int'(cprec)));
                end
                return;
            end
            KIND_WARM: begin
                width = (swidth == 6'd0) ? 1 : (swidth > 6'(SMP_W)) ? SMP_W : int'(swidth);
                w.sample = sign_extend_to(raw, width);
                push_history(w.sample);
            end
            KIND_RES: begin
                if (mode_custom) begin
                    taps = (pred_order > 6'(MAX_ORDER)) ? MAX_ORDER : int'(pred_order);
                    acc  = 0;
                    for (int t = 0; t < taps; t++) begin
                        acc += longint'(coefs[t]) * longint'($signed(history[t]));
                    end
                    acc = acc >>> qshift;
                    w.sample = res + acc[SMP_W-1:0];
                    push_history(w.sample);
                end else begin
                    h0 = history[0];
                    h1 = history[1];
                    h2 = history[2];
                    h3 = history[3];
                    case (pred_order)
                        6'd0: pred = '0;
                        6'd1: pred = h0;
                        6'd2: pred = 32'd2 * h0 - h1;
                        6'd3: pred = 32'd3 * h0 - 32'd3 * h1 + h2;
                        6'd4: pred = 32'd4 * h0 - 32'd6 * h1 + 32'd4 * h2 - h3;
                        default: begin
                            pred     = '0;
                            w.status = 1'b1;
                        end
                    endcase
                    // An unsupported order leaves the history alone.
                    if (!w.status) begin
                        w.sample = res + pred;
                        push_history(w.sample);
                    end
                end
            end
            default: return;
        endcase
        expected_samples.push_back(w);
    endfunction

    function automatic void check_word(input logic [SMP_W-1:0] s, input logic st,
                                       input logic lr);
        t_recon_word e;
        if (expected_samples.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("unexpected result word: sample %0d status %0b last %0b",
                         $signed(s), st, lr);
            end
            return;
        end
        e = expected_samples.pop_front();
        if (s !== e.sample || st !== e.status || lr !== e.last_res) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT) begin
                $display("result mismatch (exp/got): sample %0d/%0d status %0b/%0b last %0b/%0b",
                         $signed(e.sample), $signed(s), e.status, st, e.last_res, lr);
            end
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                history[i] = '0;
            end
            mode_custom = 1'b0;
            pred_order  = 6'd0;
            qshift      = 4'd0;
            swidth      = 6'd16;
            cprec       = 4'd15;
            expected_samples.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                check_word(i_res.sample, i_res.status, i_res.last_res);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_MODE:   mode_custom = i_cfg.data[0];
                    CFG_ORDER:  pred_order  = i_cfg.data[5:0];
                    CFG_QSHIFT: qshift      = i_cfg.data[3:0];
                    CFG_SWIDTH: swidth      = i_cfg.data[5:0];
                    CFG_CPREC:  cprec       = i_cfg.data[3:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                reconstruct(t_kind'(i_in.kind), i_in.slot, i_in.raw_bits, i_in.residual,
                            i_in.last);
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

>>> tb/sv/flac_lpc_synthesis_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FLAC LPC synthesis testbench
// Programs the predictor registers between subframes, feeds directed and then
// random coefficient, warm-up and residual words with random gaps on both
// channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module flac_lpc_synthesis_top_tb;
    import flac_lpc_pkg::*;

    localparam int ITEM_TARGET  = 800;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    flac_lpc_in_if  in_ch();
    flac_lpc_out_if res_ch();
    flac_lpc_cfg_if cfg_ch();

    int          fail_count;
    int          pending;
    int          items_sent;
    bit          steady;
    bit          hold_req;
    logic        cur_custom;
    logic [5:0]  cur_order;
    logic [31:0] coef_written;

    flac_lpc_synthesis_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    flac_lpc_synthesis_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input t_kind k, input logic [4:0] s, input logic [31:0] raw,
                             input logic [31:0] res, input logic lst);
        int gap;
        if (!steady && $urandom_range(99) < 12) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= k;
        in_ch.slot     <= s;
        in_ch.raw_bits <= raw;
        in_ch.residual <= res;
        in_ch.last     <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (k != KIND_NONE) begin
            items_sent++;
        end
        if (k == KIND_COEF) begin
            coef_written[s] = 1'b1;
        end
    endtask

    // A coefficient load gives no word, and the block is idle once no expected word
    // is pending; the extra pause covers the longest residual.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [7:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic m, input logic [5:0] ord, input logic [3:0] qs,
                                input logic [5:0] sw, input logic [3:0] cp);
        drain();
        put_reg(CFG_MODE, 8'(m));
        put_reg(CFG_ORDER, 8'(ord));
        put_reg(CFG_QSHIFT, 8'(qs));
        put_reg(CFG_SWIDTH, 8'(sw));
        put_reg(CFG_CPREC, 8'(cp));
        cfg_ch.valid <= 1'b0;
        cur_custom = m;
        cur_order  = ord;
    endtask

    function automatic logic [31:0] pick_residual();
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        return 32'($urandom_range(4000)) - 32'd2000;
    endfunction

    // Unwritten and most other coefficients, warm-up, residuals with a little noise.
    task automatic run_subframe();
        int taps, nwarm, nres, i;
        taps = (cur_order > 6'(MAX_ORDER)) ? MAX_ORDER : int'(cur_order);
        if (cur_custom) begin
            for (i = 0; i < taps; i++) begin
                if (!coef_written[i] || $urandom_range(3) != 0) begin
                    send_word(KIND_COEF, 5'(i), $urandom, $urandom, 1'($urandom_range(1)));
                end
            end
        end else if (taps > 4) begin
            taps = $urandom_range(1, 4);
        end
        nwarm = ($urandom_range(9) == 0) ? $urandom_range(taps) : taps;
        for (i = 0; i < nwarm; i++) begin
            send_word(KIND_WARM, 5'($urandom), $urandom, $urandom, 1'b0);
        end
        nres = $urandom_range(4, 20);
        for (i = 0; i < nres; i++) begin
            if ($urandom_range(99) < 8) begin
                send_word(t_kind'($urandom_range(3)), 5'($urandom), $urandom, $urandom,
                          1'($urandom_range(1)));
            end else begin
                send_word(KIND_RES, 5'($urandom), $urandom, pick_residual(), i == nres - 1);
            end
        end
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            // One long hold-off so that the block fills up and stops taking words.
            if (hold_req && !held) begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_ch.ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        logic        m;
        logic [5:0]  ord;
        logic [5:0]  sw;
        logic [3:0]  qs;
        logic [3:0]  cp;
        in_ch.valid    = 1'b0;
        in_ch.kind     = '0;
        in_ch.slot     = '0;
        in_ch.raw_bits = '0;
        in_ch.residual = '0;
        in_ch.last     = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        i_rst_n        = 1'b0;
        items_sent     = 0;
        steady         = 1'b0;
        hold_req       = 1'b0;
        cur_custom     = 1'b0;
        cur_order      = '0;
        coef_written   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full-width warm-up extremes, order zero, and an ignored word.
        program_regs(1'b0, 6'd0, 4'd0, 6'd32, 4'd15);
        send_word(KIND_WARM, 5'd0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(KIND_WARM, 5'd31, 32'h8000_0000, 32'h0, 1'b0);
        send_word(KIND_WARM, 5'd0, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h8000_0000, 1'b1);
        send_word(KIND_NONE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Fourth-order fixed predictor with wrapping residuals.
        program_regs(1'b0, 6'd4, 4'd0, 6'd32, 4'd15);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h8000_0000, 1'b0);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h7FFF_FFFF, 1'b1);
        // An unsupported fixed order.
        program_regs(1'b0, 6'd5, 4'd0, 6'd16, 4'd15);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h5, 1'b1);
        // Zero sample width reads as one bit; zero precision stores a zero coefficient.
        program_regs(1'b0, 6'd63, 4'd15, 6'd0, 4'd0);
        send_word(KIND_WARM, 5'd0, 32'h1, 32'h0, 1'b0);
        send_word(KIND_WARM, 5'd0, 32'hFFFF_FFFE, 32'h0, 1'b0);
        send_word(KIND_COEF, 5'd0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h1234, 1'b1);
        // Sample width above the word width, one-bit coefficient.
        program_regs(1'b0, 6'd1, 4'd15, 6'd40, 4'd1);
        send_word(KIND_WARM, 5'd0, 32'h8765_4321, 32'h0, 1'b0);
        send_word(KIND_COEF, 5'd31, 32'h1, 32'h0, 1'b0);
        // Custom order two with extreme coefficients and the largest shift.
        program_regs(1'b1, 6'd2, 4'd15, 6'd16, 4'd15);
        send_word(KIND_COEF, 5'd0, 32'h0000_4000, 32'h0, 1'b0);
        send_word(KIND_COEF, 5'd1, 32'h0000_3FFF, 32'h0, 1'b0);
        send_word(KIND_WARM, 5'd0, 32'h0000_8000, 32'h0, 1'b0);
        send_word(KIND_WARM, 5'd0, 32'h0000_7FFF, 32'h0, 1'b0);
        send_word(KIND_RES, 5'd0, 32'h0, 32'h7FFF_FFFF, 1'b1);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            m = 1'($urandom_range(1));
            case ($urandom_range(9))
                0: ord = 6'd0;
                1: ord = 6'd32;
                2: ord = 6'($urandom_range(33, 63));
                default: ord = m ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 4));
            endcase
            case ($urandom_range(3))
                0: qs = 4'd0;
                1: qs = 4'd15;
                default: qs = 4'($urandom_range(15));
            endcase
            case ($urandom_range(5))
                0: sw = 6'd0;
                1: sw = 6'd1;
                2: sw = 6'd32;
                3: sw = 6'($urandom_range(33, 63));
                default: sw = 6'($urandom_range(1, 32));
            endcase
            case ($urandom_range(4))
                0: cp = 4'd0;
                1: cp = 4'd15;
                default: cp = 4'($urandom_range(1, 15));
            endcase
            program_regs(m, ord, qs, sw, cp);
            steady = (phase >= 10 && phase < 16);
            if (phase == 4) begin
                hold_req = 1'b1;
            end
            run_subframe();
            phase++;
        end
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> flac_lpc_synthesis_top.f
+incdir+hdl
hdl/flac_lpc_pkg.sv
hdl/flac_lpc_if.sv
hdl/flac_lpc_hist.sv
hdl/flac_lpc_mac.sv
hdl/flac_lpc_synthesis_top.sv
tb/sv/flac_lpc_synthesis_checker.sv
tb/sv/flac_lpc_synthesis_top_tb.sv
